@@ rtl/core/pesp_pkg.sv @@
// pesp_pkg: shared types, widths and constants of the pose error p-controller
// used by every module in rtl/core; no dependencies
`timescale 1ns / 1ps

package pesp_pkg;

   // number of cordic micro-rotations, capped by the arctangent table
   localparam int CORDIC_STAGES = 16;
   localparam int ATAN_LEN      = 24;
   localparam int CORDIC_N      = (CORDIC_STAGES > ATAN_LEN) ? ATAN_LEN : CORDIC_STAGES;

   localparam int POS_W       = 24;
   localparam int DIFF_W      = POS_W + 1;
   localparam int ANG_W       = 16;
   localparam int EH_W        = 15;
   localparam int CW          = 33;
   localparam int ZW          = 32;
   localparam int PROD_W      = CW + DIFF_W;
   localparam int SUM_W       = PROD_W + 1;
   localparam int ERR_SHIFT   = 30;
   localparam int ERR_W       = SUM_W - ERR_SHIFT;
   localparam int GAIN_W      = 16;
   localparam int GAIN_FRAC   = 8;
   localparam int LIM_W       = 15;
   localparam int CMD_W       = 16;
   localparam int PI_W        = 18;
   localparam int TURN_SHIFT  = 27;
   localparam int TURN_PROD_W = EH_W + GAIN_W + PI_W;
   localparam int TURN_W      = TURN_PROD_W - TURN_SHIFT;
   localparam int SPEED_W     = ERR_W + GAIN_W - GAIN_FRAC;
   localparam int CSR_IDX_W   = 3;
   localparam int CSR_DATA_W  = 16;

   // front stage, cordic stages, four rotate stages, three command stages
   localparam int PIPE_LAT = CORDIC_N + 8;

   localparam logic signed [CW-1:0] CORDIC_K   = 33'sd652032874;
   localparam logic [EH_W-1:0]      HEAD_CLAMP = 15'd27296;
   localparam logic [PI_W-1:0]      PI_Q16     = 18'd205887;

   // arctangent of 2^-i in units of 2^-32 turn
   localparam logic [ZW-1:0] ATAN_TURN32 [ATAN_LEN] = '{
      32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
      32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
      32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
      32'd166886,    32'd83443,     32'd41722,     32'd20861,
      32'd10430,     32'd5215,      32'd2608,      32'd1304,
      32'd652,       32'd326,       32'd163,       32'd81
   };

   localparam logic [GAIN_W-1:0] GAIN_RESET     = 16'd256;
   localparam logic [LIM_W-1:0]  LIM_MOVE_RESET = 15'd2048;
   localparam logic [LIM_W-1:0]  LIM_TURN_RESET = 15'd4096;
   localparam logic [LIM_W-1:0]  CRUISE_RESET   = 15'd1229;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_GAIN_FORWARD  = 3'd0,
      CSR_GAIN_LATERAL  = 3'd1,
      CSR_GAIN_TURN     = 3'd2,
      CSR_LIMIT_FORWARD = 3'd3,
      CSR_LIMIT_LATERAL = 3'd4,
      CSR_LIMIT_TURN    = 3'd5,
      CSR_CRUISE_SPEED  = 3'd6
   } csr_index_type;

   typedef enum logic [1:0] {
      FWD_ZERO   = 2'd0,
      FWD_PROP   = 2'd1,
      FWD_CRUISE = 2'd2
   } fwd_mode_type;

   typedef struct packed {
      logic signed [POS_W-1:0] pose_x;
      logic signed [POS_W-1:0] pose_y;
      logic [ANG_W-1:0]        pose_heading;
      logic signed [POS_W-1:0] target_x;
      logic signed [POS_W-1:0] target_y;
      logic [ANG_W-1:0]        target_heading;
      logic [1:0]              forward_mode;
      logic                    lateral_enable;
      logic                    turn_enable;
   } req_type;

   typedef struct packed {
      logic signed [CMD_W-1:0] cmd_forward;
      logic signed [CMD_W-1:0] cmd_lateral;
      logic signed [CMD_W-1:0] cmd_turn;
   } rsp_type;

   typedef struct packed {
      logic [GAIN_W-1:0] gain_forward;
      logic [GAIN_W-1:0] gain_lateral;
      logic [GAIN_W-1:0] gain_turn;
      logic [LIM_W-1:0]  limit_forward;
      logic [LIM_W-1:0]  limit_lateral;
      logic [LIM_W-1:0]  limit_turn;
      logic [LIM_W-1:0]  cruise_speed;
   } cfg_type;

   // per-item data that rides alongside the cordic
   typedef struct packed {
      logic signed [DIFF_W-1:0] ex;
      logic signed [DIFF_W-1:0] ey;
      logic [1:0]               quad;
      logic [EH_W-1:0]          eh_mag;
      logic                     eh_neg;
      logic [1:0]               forward_mode;
      logic                     lateral_enable;
      logic                     turn_enable;
   } side_type;

   typedef struct packed {
      logic signed [CW-1:0] x;
      logic signed [CW-1:0] y;
      logic signed [ZW-1:0] z;
   } cordic_state_type;

   // robot-frame errors as magnitude and sign
   typedef struct packed {
      logic [ERR_W-1:0] fwd_mag;
      logic             fwd_neg;
      logic [ERR_W-1:0] lat_mag;
      logic             lat_neg;
      logic [EH_W-1:0]  eh_mag;
      logic             eh_neg;
      logic [1:0]       forward_mode;
      logic             lateral_enable;
      logic             turn_enable;
   } err_type;

endpackage

@@ rtl/core/pose_error_saturated_p_controller_core.sv @@
// pose_error_saturated_p_controller_core: top level, configuration registers and pipeline
// depends on pesp_pkg, pesp_front, pesp_cordic, pesp_rotate, pesp_cmd
`timescale 1ns / 1ps

// Usage
//   Input: drive req_item and raise start; the item is taken at a clock edge with
//   start high and busy low. busy is low at all times except during reset, so a
//   new item may be given on every clock cycle.
//   Result: rsp_strobe is high for exactly one cycle with the three speed
//   commands on rsp_item; the receiver cannot stall and must take it then.
//   Pipeline: one entry stage, one cordic micro-rotation per stage, four
//   stages for the frame rotation (two 33x25 multiplies per axis) and three
//   for gain, rounding and saturation. Throughput is one item per cycle.
//   Results leave in the order items came in, one result per item.
//   Configuration: csr_we writes csr_wdata (masked to the register width) into
//   register csr_index at the clock edge; index 7 is ignored. Write only while
//   no item is in flight.
//   Reset: synchronous, active high; clears the pipeline valid bits, drops any
//   item in flight and loads the default gains, limits and cruise speed. No
//   clearing pass is needed afterwards.

module pose_error_saturated_p_controller_core
   import pesp_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  req_type               req_item,
   output logic                  rsp_strobe,
   output rsp_type               rsp_item,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   cfg_type cfg_ff, cfg_in;
   logic    accept;

   logic                 front_valid;
   side_type             front_side;
   logic signed [ZW-1:0] front_z;

   logic                 cordic_valid;
   side_type             cordic_side;
   logic signed [CW-1:0] cordic_x, cordic_y;

   logic                 rot_valid;
   err_type              rot_err;

   assign busy   = reset;
   assign accept = start && !busy;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_GAIN_FORWARD:  cfg_in.gain_forward  = csr_wdata;
            CSR_GAIN_LATERAL:  cfg_in.gain_lateral  = csr_wdata;
            CSR_GAIN_TURN:     cfg_in.gain_turn     = csr_wdata;
            CSR_LIMIT_FORWARD: cfg_in.limit_forward = csr_wdata[LIM_W-1:0];
            CSR_LIMIT_LATERAL: cfg_in.limit_lateral = csr_wdata[LIM_W-1:0];
            CSR_LIMIT_TURN:    cfg_in.limit_turn    = csr_wdata[LIM_W-1:0];
            CSR_CRUISE_SPEED:  cfg_in.cruise_speed  = csr_wdata[LIM_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.gain_forward  <= GAIN_RESET;
         cfg_ff.gain_lateral  <= GAIN_RESET;
         cfg_ff.gain_turn     <= GAIN_RESET;
         cfg_ff.limit_forward <= LIM_MOVE_RESET;
         cfg_ff.limit_lateral <= LIM_MOVE_RESET;
         cfg_ff.limit_turn    <= LIM_TURN_RESET;
         cfg_ff.cruise_speed  <= CRUISE_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   pesp_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (accept),
      .in_item   (req_item),
      .out_valid (front_valid),
      .out_side  (front_side),
      .out_z     (front_z)
   );

   pesp_cordic u_cordic (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (front_valid),
      .in_side   (front_side),
      .in_z      (front_z),
      .out_valid (cordic_valid),
      .out_side  (cordic_side),
      .out_x     (cordic_x),
      .out_y     (cordic_y)
   );

   pesp_rotate u_rotate (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (cordic_valid),
      .in_side   (cordic_side),
      .in_x      (cordic_x),
      .in_y      (cordic_y),
      .out_valid (rot_valid),
      .out_err   (rot_err)
   );

   pesp_cmd u_cmd (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (rot_valid),
      .in_err     (rot_err),
      .cfg        (cfg_ff),
      .out_strobe (rsp_strobe),
      .out_item   (rsp_item)
   );

`ifndef SYNTHESIS
   // every accepted item comes out exactly after the pipeline latency
   a_accept_to_strobe: assert property (@(posedge clock) disable iff (reset)
      accept |-> ##PIPE_LAT rsp_strobe)
      else $error("item accepted without a result at pipeline latency");

   a_strobe_from_accept: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(accept, PIPE_LAT))
      else $error("result strobe without a matching accepted item");

   // zero forward mode must give a zero forward command
   a_forward_zero: assert property (@(posedge clock) disable iff (reset)
      (accept && req_item.forward_mode == FWD_ZERO) |-> ##PIPE_LAT
      (rsp_item.cmd_forward == '0))
      else $error("forward command not zero in zero mode");

   // turn command stays inside the configured limit
   a_turn_limit: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> ($signed(rsp_item.cmd_turn) <= $signed({1'b0, cfg_ff.limit_turn})
                   && $signed(rsp_item.cmd_turn) >= -$signed({1'b0, cfg_ff.limit_turn})))
      else $error("turn command beyond its limit");
`endif

endmodule

@@ rtl/core/pesp_front.sv @@
// pesp_front: entry stage, forms position and heading errors and the cordic start angle
// depends on pesp_pkg
`timescale 1ns / 1ps

module pesp_front
   import pesp_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   input  req_type              in_item,
   output logic                 out_valid,
   output side_type             out_side,
   output logic signed [ZW-1:0] out_z
);

   logic           valid_ff;
   side_type       side_ff, side_in;
   logic [ZW-1:0]  z_ff, z_in;
   logic [ANG_W-1:0] head_diff, head_abs, head_sum, resid;
   logic [1:0]     quad;

   always_comb begin
      side_in.ex = {in_item.target_x[POS_W-1], in_item.target_x}
                 - {in_item.pose_x[POS_W-1], in_item.pose_x};
      side_in.ey = {in_item.target_y[POS_W-1], in_item.target_y}
                 - {in_item.pose_y[POS_W-1], in_item.pose_y};

      // heading error wraps naturally in 16 bits, then clamp its magnitude
      head_diff = in_item.target_heading - in_item.pose_heading;
      head_abs  = head_diff[ANG_W-1] ? (~head_diff + 16'd1) : head_diff;
      side_in.eh_neg = head_diff[ANG_W-1];
      side_in.eh_mag = (head_abs > {1'b0, HEAD_CLAMP}) ? HEAD_CLAMP : head_abs[EH_W-1:0];

      // quadrant pre-rotation leaves a residual within an eighth turn
      head_sum = in_item.pose_heading + 16'd8192;
      quad     = head_sum[ANG_W-1:ANG_W-2];
      resid    = in_item.pose_heading - {quad, 14'd0};
      z_in     = {resid, 16'd0};

      side_in.quad           = quad;
      side_in.forward_mode   = in_item.forward_mode;
      side_in.lateral_enable = in_item.lateral_enable;
      side_in.turn_enable    = in_item.turn_enable;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
      if (in_valid) begin
         side_ff <= side_in;
         z_ff    <= z_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_side  = side_ff;
   assign out_z     = $signed(z_ff);

endmodule

@@ rtl/core/pesp_cordic.sv @@
// pesp_cordic: pipelined rotation-mode cordic, one micro-rotation per register stage
// depends on pesp_pkg
`timescale 1ns / 1ps

module pesp_cordic
   import pesp_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   input  side_type             in_side,
   input  logic signed [ZW-1:0] in_z,
   output logic                 out_valid,
   output side_type             out_side,
   output logic signed [CW-1:0] out_x,
   output logic signed [CW-1:0] out_y
);

   cordic_state_type st_ff    [CORDIC_N];
   side_type         side_ff  [CORDIC_N];
   logic             valid_ff [CORDIC_N];

   for (genvar i = 0; i < CORDIC_N; i++) begin : g_stage
      cordic_state_type     cur, nxt;
      side_type             cur_side;
      logic                 cur_valid;
      logic signed [CW-1:0] dx, dy;

      if (i == 0) begin : g_first
         assign cur.x     = CORDIC_K;
         assign cur.y     = '0;
         assign cur.z     = in_z;
         assign cur_side  = in_side;
         assign cur_valid = in_valid;
      end else begin : g_next
         assign cur       = st_ff[i-1];
         assign cur_side  = side_ff[i-1];
         assign cur_valid = valid_ff[i-1];
      end

      assign dx = $signed(cur.y) >>> i;
      assign dy = $signed(cur.x) >>> i;

      always_comb begin
         if (!cur.z[ZW-1]) begin
            nxt.x = cur.x - dx;
            nxt.y = cur.y + dy;
            nxt.z = cur.z - ATAN_TURN32[i];
         end else begin
            nxt.x = cur.x + dx;
            nxt.y = cur.y - dy;
            nxt.z = cur.z + ATAN_TURN32[i];
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[i] <= 1'b0;
         end else begin
            valid_ff[i] <= cur_valid;
         end
         if (cur_valid) begin
            st_ff[i]   <= nxt;
            side_ff[i] <= cur_side;
         end
      end
   end

   assign out_valid = valid_ff[CORDIC_N-1];
   assign out_side  = side_ff[CORDIC_N-1];
   assign out_x     = st_ff[CORDIC_N-1].x;
   assign out_y     = st_ff[CORDIC_N-1].y;

endmodule

@@ rtl/core/pesp_rotate.sv @@
// pesp_rotate: quadrant fix-up, rotation of the position error into the robot frame
// and rounding to metres; depends on pesp_pkg
`timescale 1ns / 1ps

module pesp_rotate
   import pesp_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   input  side_type             in_side,
   input  logic signed [CW-1:0] in_x,
   input  logic signed [CW-1:0] in_y,
   output logic                 out_valid,
   output err_type              out_err
);

   // stage 1: cosine and sine
   logic                 v1_ff;
   side_type             side1_ff;
   logic signed [CW-1:0] cos_ff, sin_ff, cos_in, sin_in;

   // stage 2: products
   logic                     v2_ff;
   side_type                 side2_ff;
   logic signed [PROD_W-1:0] p_cx_ff, p_sy_ff, p_cy_ff, p_sx_ff;

   // stage 3: sums
   logic                    v3_ff;
   side_type                side3_ff;
   logic [SUM_W-1:0]        fwd_sum_ff, lat_sum_ff;

   // stage 4: rounded magnitudes
   logic             v4_ff;
   err_type          err_ff, err_in;
   logic [SUM_W-1:0] fwd_abs, lat_abs, fwd_rnd, lat_rnd;

   always_comb begin
      case (in_side.quad)
         2'd0: begin
            cos_in = in_x;
            sin_in = in_y;
         end
         2'd1: begin
            cos_in = -in_y;
            sin_in = in_x;
         end
         2'd2: begin
            cos_in = -in_x;
            sin_in = -in_y;
         end
         default: begin
            cos_in = in_y;
            sin_in = -in_x;
         end
      endcase
   end

   always_comb begin
      fwd_abs = fwd_sum_ff[SUM_W-1] ? (~fwd_sum_ff + 1'b1) : fwd_sum_ff;
      lat_abs = lat_sum_ff[SUM_W-1] ? (~lat_sum_ff + 1'b1) : lat_sum_ff;
      fwd_rnd = fwd_abs + (SUM_W'(1) << (ERR_SHIFT - 1));
      lat_rnd = lat_abs + (SUM_W'(1) << (ERR_SHIFT - 1));

      err_in.fwd_mag        = fwd_rnd[SUM_W-1:ERR_SHIFT];
      err_in.fwd_neg        = fwd_sum_ff[SUM_W-1];
      err_in.lat_mag        = lat_rnd[SUM_W-1:ERR_SHIFT];
      err_in.lat_neg        = lat_sum_ff[SUM_W-1];
      err_in.eh_mag         = side3_ff.eh_mag;
      err_in.eh_neg         = side3_ff.eh_neg;
      err_in.forward_mode   = side3_ff.forward_mode;
      err_in.lateral_enable = side3_ff.lateral_enable;
      err_in.turn_enable    = side3_ff.turn_enable;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
      end
      if (in_valid) begin
         cos_ff   <= cos_in;
         sin_ff   <= sin_in;
         side1_ff <= in_side;
      end
      if (v1_ff) begin
         p_cx_ff  <= cos_ff * side1_ff.ex;
         p_sy_ff  <= sin_ff * side1_ff.ey;
         p_cy_ff  <= cos_ff * side1_ff.ey;
         p_sx_ff  <= sin_ff * side1_ff.ex;
         side2_ff <= side1_ff;
      end
      if (v2_ff) begin
         // forward = c*ex + s*ey, lateral = c*ey - s*ex
         fwd_sum_ff <= {p_cx_ff[PROD_W-1], p_cx_ff} + {p_sy_ff[PROD_W-1], p_sy_ff};
         lat_sum_ff <= {p_cy_ff[PROD_W-1], p_cy_ff} - {p_sx_ff[PROD_W-1], p_sx_ff};
         side3_ff   <= side2_ff;
      end
      if (v3_ff) begin
         err_ff <= err_in;
      end
   end

   assign out_valid = v4_ff;
   assign out_err   = err_ff;

endmodule

@@ rtl/core/pesp_cmd.sv @@
// pesp_cmd: gain, rounding, saturation and mode selection of the three speed commands
// depends on pesp_pkg
`timescale 1ns / 1ps

module pesp_cmd
   import pesp_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    in_valid,
   input  err_type in_err,
   input  cfg_type cfg,
   output logic    out_strobe,
   output rsp_type out_item
);

   localparam int PM_W = ERR_W + GAIN_W;
   localparam int T1_W = EH_W + GAIN_W;

   function automatic logic [CMD_W-1:0] sat_apply(input logic [SPEED_W-1:0] mag,
                                                  input logic [LIM_W-1:0]   limit,
                                                  input logic               neg);
      logic [LIM_W-1:0] m;
      logic [CMD_W-1:0] m16;
      m   = (mag > SPEED_W'(limit)) ? limit : mag[LIM_W-1:0];
      m16 = {1'b0, m};
      return neg ? (~m16 + 1'b1) : m16;
   endfunction

   // stage 1: gain products
   logic                v1_ff;
   err_type             e1_ff;
   logic [PM_W-1:0]     pf_ff, pl_ff;
   logic [T1_W-1:0]     pt1_ff;

   // stage 2: rounded speeds, turn scaled by pi
   logic                v2_ff;
   err_type             e2_ff;
   logic [SPEED_W-1:0]  fr_ff, lr_ff;
   logic [TURN_PROD_W-1:0] pt2_ff;
   logic [PM_W-1:0]     pf_rnd, pl_rnd;

   // stage 3: output register
   logic                strobe_ff;
   rsp_type             item_ff, item_in;
   logic [TURN_PROD_W-1:0] pt_rnd;
   logic [TURN_W-1:0]   tr;

   always_comb begin
      pf_rnd = pf_ff + (PM_W'(1) << (GAIN_FRAC - 1));
      pl_rnd = pl_ff + (PM_W'(1) << (GAIN_FRAC - 1));
   end

   always_comb begin
      pt_rnd = pt2_ff + (TURN_PROD_W'(1) << (TURN_SHIFT - 1));
      tr     = pt_rnd[TURN_PROD_W-1:TURN_SHIFT];

      case (e2_ff.forward_mode)
         FWD_PROP:   item_in.cmd_forward = sat_apply(fr_ff, cfg.limit_forward, e2_ff.fwd_neg);
         FWD_CRUISE: item_in.cmd_forward = {1'b0, cfg.cruise_speed};
         default:    item_in.cmd_forward = '0;
      endcase

      // lateral and turn leave negated, so the error sign is inverted here
      item_in.cmd_lateral = e2_ff.lateral_enable
                          ? sat_apply(lr_ff, cfg.limit_lateral, !e2_ff.lat_neg) : '0;
      item_in.cmd_turn    = e2_ff.turn_enable
                          ? sat_apply(SPEED_W'(tr), cfg.limit_turn, !e2_ff.eh_neg) : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff     <= 1'b0;
         v2_ff     <= 1'b0;
         strobe_ff <= 1'b0;
      end else begin
         v1_ff     <= in_valid;
         v2_ff     <= v1_ff;
         strobe_ff <= v2_ff;
      end
      if (in_valid) begin
         pf_ff  <= in_err.fwd_mag * cfg.gain_forward;
         pl_ff  <= in_err.lat_mag * cfg.gain_lateral;
         pt1_ff <= in_err.eh_mag * cfg.gain_turn;
         e1_ff  <= in_err;
      end
      if (v1_ff) begin
         fr_ff  <= pf_rnd[PM_W-1:GAIN_FRAC];
         lr_ff  <= pl_rnd[PM_W-1:GAIN_FRAC];
         pt2_ff <= pt1_ff * PI_Q16;
         e2_ff  <= e1_ff;
      end
      if (v2_ff) begin
         item_ff <= item_in;
      end
   end

   assign out_strobe = strobe_ff;
   assign out_item   = item_ff;

endmodule

@@ verif/pose_error_saturated_p_controller_core_test.sv @@
// pose_error_saturated_p_controller_core_test: self-checking bench for the pose error p-controller
// drives pose items with random gaps, predicts the three speed commands per item, checks each result
// depends on pesp_pkg and the pose_error_saturated_p_controller_core rtl
`timescale 1ns / 1ps

module pose_error_saturated_p_controller_core_test;
   import pesp_pkg::*;

   localparam int STALL_LIMIT = 1000;
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED_INDEX = 3'd7;
   localparam logic [1:0] FWD_UNUSED = 2'd3;

   localparam longint HEAD_LIMIT   = 27296;
   localparam longint TURN_PI      = 205887;
   localparam longint CORDIC_START = 652032874;
   // arctangent of 2^-i in 2^-32 turn
   localparam longint ATAN_STEP [24] = '{
      536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
      10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
      41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81
   };

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   req_type req_item = '0;
   logic rsp_strobe;
   rsp_type rsp_item;
   logic csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   cfg_type shadow_cfg;
   req_type pending_poses[$];
   rsp_type expected_commands[$];
   rsp_type oldest_command;
   int mismatch_count = 0;
   int quiet_cycles = 0;
   int gap_left = 0;
   int burst_left = 0;

   pose_error_saturated_p_controller_core DUT (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_item(req_item),
      .rsp_strobe(rsp_strobe),
      .rsp_item(rsp_item),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always #5 clock = ~clock;

   function automatic longint round_half_away(longint v, int sh);
      longint mag;
      mag = (v < 0) ? -v : v;
      mag = (mag + (64'sd1 <<< (sh - 1))) >>> sh;
      return (v < 0) ? -mag : mag;
   endfunction

   function automatic longint limit_signed(longint err, longint mag, longint lim);
      if (mag > lim) mag = lim;
      if (err < 0) return -mag;
      if (err > 0) return mag;
      return 0;
   endfunction

   function automatic longint scaled_speed(longint err, longint gain, longint lim);
      longint mag;
      mag = (err < 0) ? -err : err;
      mag = (mag * gain + 128) >>> 8;
      return limit_signed(err, mag, lim);
   endfunction

   function automatic rsp_type predict_commands(req_type it, cfg_type cfg);
      longint ex, ey, eh, x, y, z, dx, dy, c, s;
      longint fwd_err, lat_err, vf, vl, vt, mag;
      logic [15:0] dh, hsum, resid;
      logic [1:0] quad;
      rsp_type res;
      ex = $signed(it.target_x) - $signed(it.pose_x);
      ey = $signed(it.target_y) - $signed(it.pose_y);
      dh = it.target_heading - it.pose_heading;
      eh = $signed(dh);
      if (eh > HEAD_LIMIT) eh = HEAD_LIMIT;
      if (eh < -HEAD_LIMIT) eh = -HEAD_LIMIT;

      // quadrant pre-rotation leaves the residual within +/-45 degrees
      hsum = it.pose_heading + 16'd8192;
      quad = hsum[15:14];
      resid = it.pose_heading - {quad, 14'd0};
      x = CORDIC_START;
      y = 0;
      z = $signed(resid);
      z = z * 65536;
      for (int i = 0; i < CORDIC_N; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (z >= 0) begin
            x = x - dx;
            y = y + dy;
            z = z - ATAN_STEP[i];
         end else begin
            x = x + dx;
            y = y - dy;
            z = z + ATAN_STEP[i];
         end
      end
      case (quad)
         2'd0: begin c = x; s = y; end
         2'd1: begin c = -y; s = x; end
         2'd2: begin c = -x; s = -y; end
         default: begin c = y; s = -x; end
      endcase
      fwd_err = round_half_away(c * ex + s * ey, 30);
      lat_err = round_half_away(c * ey - s * ex, 30);

      vf = 0;
      if (it.forward_mode == FWD_PROP)
         vf = scaled_speed(fwd_err, cfg.gain_forward, cfg.limit_forward);
      else if (it.forward_mode == FWD_CRUISE)
         vf = cfg.cruise_speed;
      vl = 0;
      if (it.lateral_enable)
         vl = scaled_speed(lat_err, cfg.gain_lateral, cfg.limit_lateral);
      vt = 0;
      if (it.turn_enable) begin
         mag = (eh < 0) ? -eh : eh;
         mag = (mag * longint'(cfg.gain_turn) * TURN_PI + (64'sd1 <<< 26)) >>> 27;
         vt = limit_signed(eh, mag, cfg.limit_turn);
      end
      // lateral and turn leave negated
      vl = -vl;
      vt = -vt;
      res.cmd_forward = vf[15:0];
      res.cmd_lateral = vl[15:0];
      res.cmd_turn = vt[15:0];
      return res;
   endfunction

   function automatic req_type make_item(logic [23:0] px, logic [23:0] py, logic [15:0] ph,
                                         logic [23:0] tx, logic [23:0] ty, logic [15:0] th,
                                         logic [1:0] mode, logic lat, logic turn);
      req_type it;
      it.pose_x = px;
      it.pose_y = py;
      it.pose_heading = ph;
      it.target_x = tx;
      it.target_y = ty;
      it.target_heading = th;
      it.forward_mode = mode;
      it.lateral_enable = lat;
      it.turn_enable = turn;
      return it;
   endfunction

   function automatic req_type make_random_item();
      req_type it;
      int span, dx, dy, dh;
      it.pose_x = 24'($urandom());
      it.pose_y = 24'($urandom());
      case ($urandom_range(0, 4))
         0: span = 16;
         1: span = 4096;
         2: span = 65536;
         3: span = 1 << 22;
         default: span = 0;
      endcase
      if (span == 0) begin
         it.target_x = 24'($urandom());
         it.target_y = 24'($urandom());
      end else begin
         dx = $urandom_range(0, 2 * span) - span;
         dy = $urandom_range(0, 2 * span) - span;
         it.target_x = it.pose_x + dx[23:0];
         it.target_y = it.pose_y + dy[23:0];
      end
      it.pose_heading = 16'($urandom());
      if ($urandom_range(0, 1) == 0) begin
         it.target_heading = 16'($urandom());
      end else begin
         dh = $urandom_range(0, 4096) - 2048;
         it.target_heading = it.pose_heading + dh[15:0];
      end
      if ($urandom_range(0, 9) < 6)
         it.forward_mode = FWD_PROP;
      else
         it.forward_mode = 2'($urandom_range(0, 3));
      it.lateral_enable = ($urandom_range(0, 4) != 0);
      it.turn_enable = ($urandom_range(0, 4) != 0);
      return it;
   endfunction

   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 55) return 0;
      if (roll < 85) return $urandom_range(1, 3);
      if (roll < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // appends one item at the tail of the pending queue
   task automatic append_pose(req_type it);
      pending_poses.insert(pending_poses.size(), it);
   endtask

   task automatic queue_random_items(int count);
      repeat (count) append_pose(make_random_item());
   endtask

   // returns at a rising edge once every item is taken and every result seen
   task automatic wait_drained();
      do @(negedge clock);
      while (pending_poses.size() != 0 || start || expected_commands.size() != 0);
      @(posedge clock);
   endtask

   // call at a rising edge; the write lands on the next one
   task automatic write_register(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      case (idx)
         CSR_GAIN_FORWARD:  shadow_cfg.gain_forward = val;
         CSR_GAIN_LATERAL:  shadow_cfg.gain_lateral = val;
         CSR_GAIN_TURN:     shadow_cfg.gain_turn = val;
         CSR_LIMIT_FORWARD: shadow_cfg.limit_forward = val[LIM_W-1:0];
         CSR_LIMIT_LATERAL: shadow_cfg.limit_lateral = val[LIM_W-1:0];
         CSR_LIMIT_TURN:    shadow_cfg.limit_turn = val[LIM_W-1:0];
         CSR_CRUISE_SPEED:  shadow_cfg.cruise_speed = val[LIM_W-1:0];
         default: ;
      endcase
   endtask

   task automatic program_registers(logic [15:0] gf, logic [15:0] gl, logic [15:0] gt,
                                    logic [15:0] lf, logic [15:0] ll, logic [15:0] lt,
                                    logic [15:0] cruise);
      write_register(CSR_GAIN_FORWARD, gf);
      write_register(CSR_GAIN_LATERAL, gl);
      write_register(CSR_GAIN_TURN, gt);
      write_register(CSR_LIMIT_FORWARD, lf);
      write_register(CSR_LIMIT_LATERAL, ll);
      write_register(CSR_LIMIT_TURN, lt);
      write_register(CSR_CRUISE_SPEED, cruise);
      // the spare index must change nothing
      write_register(CSR_UNUSED_INDEX, 16'($urandom_range(0, 65535)));
      csr_we <= 1'b0;
   endtask

   task automatic compare_command(string field, logic signed [15:0] want,
                                  logic signed [15:0] got);
      if (want !== got) begin
         mismatch_count++;
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
      end
   endtask

   // driver: one item per start, random gaps with back-to-back runs
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
         gap_left = 0;
         burst_left = 0;
      end else begin
         if (start && !busy)
            expected_commands.insert(expected_commands.size(),
                                     predict_commands(req_item, shadow_cfg));
         if (!(start && busy)) begin
            if (gap_left > 0) begin
               gap_left--;
               start <= 1'b0;
            end else if (pending_poses.size() != 0) begin
               req_item <= pending_poses.pop_front();
               start <= 1'b1;
               if (burst_left > 0) begin
                  burst_left--;
                  gap_left = 0;
               end else begin
                  gap_left = pick_gap();
                  if ($urandom_range(0, 24) == 0) burst_left = $urandom_range(16, 80);
               end
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         if (expected_commands.size() == 0) begin
            mismatch_count++;
            $display("%0t: unexpected result, expected none, actual %h", $time, rsp_item);
         end else begin
            oldest_command = expected_commands.pop_front();
            compare_command("cmd_forward", oldest_command.cmd_forward, rsp_item.cmd_forward);
            compare_command("cmd_lateral", oldest_command.cmd_lateral, rsp_item.cmd_lateral);
            compare_command("cmd_turn", oldest_command.cmd_turn, rsp_item.cmd_turn);
         end
      end
   end

   // watchdog on cycles with no handshake of any kind
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe || csr_we) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      shadow_cfg.gain_forward = 16'd256;
      shadow_cfg.gain_lateral = 16'd256;
      shadow_cfg.gain_turn = 16'd256;
      shadow_cfg.limit_forward = 15'd2048;
      shadow_cfg.limit_lateral = 15'd2048;
      shadow_cfg.limit_turn = 15'd4096;
      shadow_cfg.cruise_speed = 15'd1229;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // directed items under the reset settings
      // zero error
      append_pose(make_item(24'h0, 24'h0, 16'h0, 24'h0, 24'h0, 16'h0,
                            FWD_PROP, 1'b1, 1'b1));
      // largest position errors both ways
      append_pose(make_item(24'h800000, 24'h800000, 16'h0, 24'h7FFFFF, 24'h7FFFFF,
                            16'h0, FWD_PROP, 1'b1, 1'b1));
      append_pose(make_item(24'h7FFFFF, 24'h7FFFFF, 16'h8000, 24'h800000, 24'h800000,
                            16'h8000, FWD_PROP, 1'b1, 1'b1));
      // heading error at and beyond the clamp, and the half turn wrap
      append_pose(make_item(24'h0, 24'h0, 16'h0, 24'h0, 24'h0, 16'd27296,
                            FWD_PROP, 1'b1, 1'b1));
      append_pose(make_item(24'h0, 24'h0, 16'h0, 24'h0, 24'h0, 16'd27297,
                            FWD_PROP, 1'b1, 1'b1));
      append_pose(make_item(24'h0, 24'h0, 16'd27296, 24'h0, 24'h0, 16'h0,
                            FWD_PROP, 1'b1, 1'b1));
      append_pose(make_item(24'h0, 24'h0, 16'h0, 24'h0, 24'h0, 16'h8000,
                            FWD_PROP, 1'b1, 1'b1));
      append_pose(make_item(24'h0, 24'h0, 16'h0, 24'h0, 24'h0, 16'h7FFF,
                            FWD_PROP, 1'b1, 1'b1));
      append_pose(make_item(24'h0, 24'h0, 16'hFFFF, 24'h0, 24'h0, 16'h0,
                            FWD_PROP, 1'b1, 1'b1));
      // every forward mode, axes off
      append_pose(make_item(24'h0, 24'h0, 16'h0, 24'd1000, 24'd500, 16'h100,
                            FWD_ZERO, 1'b1, 1'b1));
      append_pose(make_item(24'h0, 24'h0, 16'h0, 24'd1000, 24'd500, 16'h100,
                            FWD_CRUISE, 1'b1, 1'b1));
      append_pose(make_item(24'h0, 24'h0, 16'h0, 24'd1000, 24'd500, 16'h100,
                            FWD_UNUSED, 1'b1, 1'b1));
      append_pose(make_item(24'h0, 24'h0, 16'h0, 24'd1000, 24'd500, 16'h100,
                            FWD_PROP, 1'b0, 1'b0));
      // quadrant boundaries of the robot heading
      append_pose(make_item(24'h0, 24'h0, 16'h1FFF, 24'd1000, 24'hFFF830, 16'h0,
                            FWD_PROP, 1'b1, 1'b1));
      append_pose(make_item(24'h0, 24'h0, 16'h2000, 24'd1000, 24'hFFF830, 16'h0,
                            FWD_PROP, 1'b1, 1'b1));
      append_pose(make_item(24'h0, 24'h0, 16'h6000, 24'd1000, 24'hFFF830, 16'h0,
                            FWD_PROP, 1'b1, 1'b1));
      append_pose(make_item(24'h0, 24'h0, 16'hA000, 24'd1000, 24'hFFF830, 16'h0,
                            FWD_PROP, 1'b1, 1'b1));
      append_pose(make_item(24'h0, 24'h0, 16'hE000, 24'd1000, 24'hFFF830, 16'h0,
                            FWD_PROP, 1'b1, 1'b1));
      append_pose(make_item(24'h0, 24'h0, 16'hFFFF, 24'd1000, 24'hFFF830, 16'hFFFF,
                            FWD_PROP, 1'b1, 1'b1));
      // one lsb errors, rounding near zero
      append_pose(make_item(24'h0, 24'h0, 16'h1000, 24'd1, 24'h0, 16'h1000,
                            FWD_PROP, 1'b1, 1'b1));
      append_pose(make_item(24'd5, 24'd5, 16'h5000, 24'd4, 24'd6, 16'h4FFF,
                            FWD_PROP, 1'b1, 1'b1));
      queue_random_items(300);
      wait_drained();

      program_registers(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                        16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                        16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                        16'($urandom_range(0, 65535)));
      queue_random_items(400);
      wait_drained();

      // widest settings; limits written with the top bit set to check the mask
      program_registers(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      queue_random_items(300);
      wait_drained();

      program_registers(16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0);
      queue_random_items(200);
      wait_drained();

      program_registers(16'($urandom_range(1, 600)), 16'($urandom_range(1, 600)),
                        16'($urandom_range(1, 600)),
                        16'($urandom_range(0, 32767)), 16'($urandom_range(0, 32767)),
                        16'($urandom_range(0, 32767)), 16'($urandom_range(0, 32767)));
      queue_random_items(400);
      wait_drained();

      // gains near unity with open limits keep most commands proportional
      program_registers(16'($urandom_range(0, 511)), 16'($urandom_range(0, 511)),
                        16'($urandom_range(0, 511)),
                        16'h7FFF, 16'h7FFF, 16'h7FFF, 16'($urandom_range(0, 32767)));
      queue_random_items(400);
      wait_drained();

      repeat (PIPE_LAT + 10) @(posedge clock);
      if (mismatch_count == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule

@@ filelist.f @@
rtl/core/pesp_pkg.sv
rtl/core/pesp_front.sv
rtl/core/pesp_cordic.sv
rtl/core/pesp_rotate.sv
rtl/core/pesp_cmd.sv
rtl/core/pose_error_saturated_p_controller_core.sv
verif/pose_error_saturated_p_controller_core_test.sv
